/* design/paged_upload_frame_checker_unit_macros.svh */
// Assertion helpers for the paged upload checker.
`ifndef PAGED_UPLOAD_FRAME_CHECKER_UNIT_MACROS_SVH
`define PAGED_UPLOAD_FRAME_CHECKER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define PUF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/puf_pkg.sv */
package puf_pkg;

    // Memory image and page geometry
    localparam int MEM_SIZE   = 32768;
    localparam int PAGE_SIZE  = 64;
    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);

    // Field widths
    localparam int ACTION_W    = 2;
    localparam int ADDR_W      = 16;
    localparam int PLEN_W      = 8;
    localparam int CRC_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 4;
    localparam int COUNT_W     = 16;
    localparam int START_W     = 15;
    localparam int LEN_W       = 16;
    localparam int PCNT_W      = $clog2(PAGE_SIZE + 1);
    localparam int SUM_W       = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // CRC-32, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 2'd0,
        ACT_HEADER = 2'd1,
        ACT_DATA   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_ADDRESS = 2'd0,
        REG_TOTAL_LENGTH  = 2'd1,
        REG_EXPECTED_CRC  = 2'd2
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_READY      = 4'd0,
        ST_SEND       = 4'd1,
        ST_PAGE_ACK   = 4'd2,
        ST_DONE       = 4'd3,
        ST_BAD_RANGE  = 4'd4,
        ST_BAD_FRAME  = 4'd5,
        ST_PAGE_CRC   = 4'd6,
        ST_TOTAL_CRC  = 4'd7,
        ST_UNEXPECTED = 4'd8
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic [CRC_W-1:0]     crc;
        logic                 last;
    } result_t;

    // Fold one byte into a running CRC-32, one bit per step
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

/* design/puf_if.sv */
// Input channel: one beat per upload item
interface puf_item_if;
    logic                           valid;
    logic                           ready;
    logic [puf_pkg::ACTION_W-1:0]   action;
    logic [puf_pkg::ADDR_W-1:0]     page_address;
    logic [puf_pkg::PLEN_W-1:0]     page_length;
    logic [puf_pkg::CRC_W-1:0]      page_crc;
    logic [puf_pkg::BYTE_W-1:0]     data_byte;

    modport source (output valid, action, page_address, page_length, page_crc, data_byte,
                    input ready);
    modport sink (input valid, action, page_address, page_length, page_crc, data_byte,
                  output ready);
endinterface

// Output channel: one beat per result
interface puf_result_if;
    logic                           valid;
    logic                           ready;
    logic [puf_pkg::STATUS_W-1:0]   status;
    logic [puf_pkg::COUNT_W-1:0]    received_count;
    logic [puf_pkg::CRC_W-1:0]      crc_value;
    logic                           last_of_run;

    modport source (output valid, status, received_count, crc_value, last_of_run,
                    input ready);
    modport sink (input valid, status, received_count, crc_value, last_of_run,
                  output ready);
endinterface

/* design/paged_upload_frame_checker_unit.sv */
// Channel   Dir  Beat contents
// item      in   action, page_address, page_length, page_crc, data_byte
// result    out  status, received_count, crc_value, last_of_run
// cfg_*     in   register write: index, data (no handshake)
//
// Each item is checked in the cycle it is accepted; one item per cycle while item.ready is high.
// Results queue in a four-entry register FIFO; an item that ends an upload
// pushes two results, so item.ready drops when fewer than two slots are free.
// rst_n clears phase, counters, CRC state, registers and the result FIFO.
// A stalled result side fills the FIFO and then holds off input beats.
module paged_upload_frame_checker_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [puf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [puf_pkg::CFG_DATA_W-1:0]     cfg_data,
    puf_item_if.sink                           item,
    puf_result_if.source                       result
);
    import puf_pkg::*;

    // Configuration registers
    logic [START_W-1:0]  start_address_reg;
    logic [LEN_W-1:0]    total_length_reg;
    logic [CRC_W-1:0]    expected_crc_reg;

    // Upload state
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  received_reg, received_next;
    logic [CRC_W-1:0]    total_crc_reg, total_crc_next;
    logic [CRC_W-1:0]    page_crc_reg, page_crc_next;
    logic [PCNT_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [CRC_W-1:0]    page_expected_reg, page_expected_next;
    logic [PCNT_W-1:0]   page_len_reg, page_len_next;

    // Result FIFO
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [1:0]          push_cnt;
    result_t             res0, res1;
    logic                accept, pop;

    // Item decode helpers
    logic [SUM_W-1:0]    range_end;
    logic                range_bad;
    logic [LEN_W-1:0]    len_left;
    logic [SUM_W-1:0]    expected_addr;
    logic [SUM_W-1:0]    page_end;
    logic                header_bad;
    logic [CRC_W-1:0]    page_crc_upd, total_crc_upd;
    logic [CRC_W-1:0]    page_final, total_final;
    logic [COUNT_W-1:0]  received_sum;

    assign accept = item.valid && item.ready;
    assign pop    = result.valid && result.ready;

    // Hold off input unless two result slots are free
    assign item.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
            total_length_reg  <= '0;
            expected_crc_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_ADDRESS: start_address_reg <= cfg_data[START_W-1:0];
                REG_TOTAL_LENGTH:  total_length_reg  <= cfg_data[LEN_W-1:0];
                REG_EXPECTED_CRC:  expected_crc_reg  <= cfg_data[CRC_W-1:0];
                default:           ;
            endcase
        end
    end

    // Range, frame and CRC terms
    always_comb
    begin
        range_end = {2'b00, start_address_reg} + {1'b0, total_length_reg};
        range_bad = (total_length_reg == '0)
                    || ({2'b00, start_address_reg} >= SUM_W'(MEM_SIZE))
                    || (range_end > SUM_W'(MEM_SIZE));

        len_left      = (total_length_reg > received_reg) ? (total_length_reg - received_reg)
                                                          : '0;
        expected_addr = {2'b00, start_address_reg} + {1'b0, received_reg};
        page_end      = {1'b0, item.page_address}
                        + {{(SUM_W-PLEN_W){1'b0}}, item.page_length} - SUM_W'(1);
        header_bad    = ({1'b0, item.page_address} != expected_addr)
                        || (item.page_length == '0)
                        || (item.page_length > PLEN_W'(PAGE_SIZE))
                        || ({{(LEN_W-PLEN_W){1'b0}}, item.page_length} > len_left)
                        || (({1'b0, item.page_address} >> PAGE_SHIFT)
                            != (page_end >> PAGE_SHIFT));

        page_crc_upd  = crc_byte(page_crc_reg, item.data_byte);
        total_crc_upd = crc_byte(total_crc_reg, item.data_byte);
        page_final    = ~page_crc_upd;
        total_final   = ~total_crc_upd;
        received_sum  = received_reg + {{(COUNT_W-PCNT_W){1'b0}}, page_len_reg};
    end

    // Next state and results for the accepted beat
    always_comb
    begin
        phase_next         = phase_reg;
        received_next      = received_reg;
        total_crc_next     = total_crc_reg;
        page_crc_next      = page_crc_reg;
        bytes_left_next    = bytes_left_reg;
        page_expected_next = page_expected_reg;
        page_len_next      = page_len_reg;
        push_cnt           = 2'd0;
        res0               = '{status: ST_UNEXPECTED, count: received_reg, crc: '0, last: 1'b1};
        res1               = '{status: ST_DONE, count: received_reg, crc: '0, last: 1'b1};

        if (accept)
        begin
            push_cnt = 2'd1;
            unique case (action_t'(item.action))
                ACT_START:
                begin
                    if (range_bad)
                    begin
                        phase_next  = PH_IDLE;
                        res0.status = ST_BAD_RANGE;
                    end
                    else
                    begin
                        phase_next      = PH_HEADER;
                        received_next   = '0;
                        total_crc_next  = CRC_ONES;
                        page_crc_next   = CRC_ONES;
                        bytes_left_next = '0;
                        page_len_next   = '0;
                        res0.status     = ST_READY;
                        res0.count      = '0;
                    end
                end
                ACT_HEADER:
                begin
                    if (phase_reg != PH_HEADER)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (header_bad)
                    begin
                        phase_next  = PH_IDLE;
                        res0.status = ST_BAD_FRAME;
                    end
                    else
                    begin
                        phase_next         = PH_DATA;
                        page_len_next      = item.page_length[PCNT_W-1:0];
                        bytes_left_next    = item.page_length[PCNT_W-1:0];
                        page_expected_next = item.page_crc;
                        page_crc_next      = CRC_ONES;
                        res0.status        = ST_SEND;
                    end
                end
                ACT_DATA:
                begin
                    if (phase_reg != PH_DATA)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        page_crc_next  = page_crc_upd;
                        total_crc_next = total_crc_upd;
                        if (bytes_left_reg > PCNT_W'(1))
                        begin
                            // Mid-page byte: no result
                            bytes_left_next = bytes_left_reg - PCNT_W'(1);
                            push_cnt        = 2'd0;
                        end
                        else
                        begin
                            bytes_left_next = '0;
                            res0.crc        = page_final;
                            if (page_final != page_expected_reg)
                            begin
                                phase_next  = PH_IDLE;
                                res0.status = ST_PAGE_CRC;
                            end
                            else
                            begin
                                received_next = received_sum;
                                res0.status   = ST_PAGE_ACK;
                                res0.count    = received_sum;
                                if (received_sum < total_length_reg)
                                begin
                                    phase_next = PH_HEADER;
                                end
                                else
                                begin
                                    // Upload complete: ack, then total check
                                    phase_next  = PH_IDLE;
                                    push_cnt    = 2'd2;
                                    res0.last   = 1'b0;
                                    res1.status = (total_final == expected_crc_reg)
                                                  ? ST_DONE : ST_TOTAL_CRC;
                                    res1.count  = received_sum;
                                    res1.crc    = total_final;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Upload state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            received_reg      <= '0;
            total_crc_reg     <= CRC_ONES;
            page_crc_reg      <= CRC_ONES;
            bytes_left_reg    <= '0;
            page_expected_reg <= '0;
            page_len_reg      <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            received_reg      <= received_next;
            total_crc_reg     <= total_crc_next;
            page_crc_reg      <= page_crc_next;
            bytes_left_reg    <= bytes_left_next;
            page_expected_reg <= page_expected_next;
            page_len_reg      <= page_len_next;
        end
    end

    // Push results into the FIFO
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    // Advance FIFO pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
        end
    end

    // Drive the head of the FIFO
    assign result.valid          = (count_reg != '0);
    assign result.status         = queue_reg[rd_ptr_reg].status;
    assign result.received_count = queue_reg[rd_ptr_reg].count;
    assign result.crc_value      = queue_reg[rd_ptr_reg].crc;
    assign result.last_of_run    = queue_reg[rd_ptr_reg].last;

endmodule

/* design/puf_checker.sv */
`include "paged_upload_frame_checker_unit_macros.svh"

module puf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [puf_pkg::STATUS_W-1:0]   out_status,
    input logic [puf_pkg::COUNT_W-1:0]    out_count,
    input logic [puf_pkg::CRC_W-1:0]      out_crc,
    input logic                           out_last
);
    import puf_pkg::*;

    // A stalled result beat holds
    `PUF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_count) && $stable(out_crc) && $stable(out_last), "result beat changed while stalled")

    // Only the page ack that completes an upload is followed by another result
    `PUF_ASSERT_NOW(a_first_is_ack, clk, rst_n, out_valid && !out_last, out_status == ST_PAGE_ACK, "non-final result is not a page ack")

    // The total check follows at once
    `PUF_ASSERT_NEXT(a_total_follows, clk, rst_n, out_valid && out_ready && !out_last, out_valid && out_last && (out_status == ST_DONE || out_status == ST_TOTAL_CRC), "total check did not follow final page ack")

    // Outcomes without a CRC report zero and end the run
    `PUF_ASSERT_NOW(a_crc_zero, clk, rst_n, out_valid && (out_status == ST_READY || out_status == ST_SEND || out_status == ST_BAD_RANGE || out_status == ST_BAD_FRAME || out_status == ST_UNEXPECTED), out_crc == '0 && out_last, "non-CRC outcome carries CRC or is not final")

endmodule

bind paged_upload_frame_checker_unit puf_checker u_puf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status),
    .out_count  (result.received_count),
    .out_crc    (result.crc_value),
    .out_last   (result.last_of_run)
);

/* tb/tb_paged_upload_frame_checker_unit.sv */
`timescale 1ns / 1ps

module tb_paged_upload_frame_checker_unit;
    import puf_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        bit                  is_reg;
        cfg_reg_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   addr;
        logic [PLEN_W-1:0]   len;
        logic [CRC_W-1:0]    crc;
        logic [BYTE_W-1:0]   dbyte;
        bit                  typed;
        result_t             want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    puf_item_if   item_ch();
    puf_result_if res_ch();

    paged_upload_frame_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Mirror of the registers and the upload state
    logic [START_W-1:0] reg_start;
    logic [LEN_W-1:0]   reg_total;
    logic [CRC_W-1:0]   reg_expect;
    phase_t             up_phase;
    logic [COUNT_W-1:0] up_count;
    logic [CRC_W-1:0]   up_total_crc;
    logic [CRC_W-1:0]   up_page_crc;
    logic [CRC_W-1:0]   up_page_expect;
    logic [6:0]         up_left;
    logic [6:0]         up_page_len;

    result_t     owed_results[$];
    step_row_t   plan[$];
    bit          row_typed;
    result_t     row_result;
    int          send_gap_pct = 7;
    int          recv_stall_pct = 58;
    int unsigned offered;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned uploads_clean;
    int unsigned mismatches;
    int unsigned cycle_count;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Bail out if the run hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Stall the result side at random
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Reflected CRC-32, one data bit per step
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] d);
        logic [CRC_W-1:0] r;
        logic fb;
        r = c;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb = r[0] ^ d[i];
            r = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void owe(input status_t s, input logic [CRC_W-1:0] c, input logic l);
        owed_results.push_back('{status: s, count: up_count, crc: c, last: l});
    endfunction

    // Work out the results of one accepted item and advance the upload state
    function automatic void judge_item(input logic [ACTION_W-1:0] act,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [PLEN_W-1:0] len,
                                       input logic [CRC_W-1:0] pcrc,
                                       input logic [BYTE_W-1:0] dbyte);
        int owed_left;
        int first_page;
        int last_page;
        bit bad;
        logic [CRC_W-1:0] page_final;
        logic [CRC_W-1:0] total_final;
        if (act == ACT_START)
        begin
            if (reg_total == 0 || int'(reg_start) + int'(reg_total) > MEM_SIZE)
            begin
                up_phase = PH_IDLE;
                owe(ST_BAD_RANGE, '0, 1'b1);
            end
            else
            begin
                up_phase = PH_HEADER;
                up_count = '0;
                up_total_crc = CRC_ONES;
                up_page_crc = CRC_ONES;
                up_left = '0;
                up_page_len = '0;
                owe(ST_READY, '0, 1'b1);
            end
        end
        else if (act == ACT_HEADER && up_phase == PH_HEADER)
        begin
            owed_left = (reg_total > up_count) ? int'(reg_total) - int'(up_count) : 0;
            first_page = int'(addr) / PAGE_SIZE;
            last_page = (int'(addr) + int'(len) - 1) / PAGE_SIZE;
            bad = int'(addr) != int'(reg_start) + int'(up_count) || len == 0 ||
                  len > PAGE_SIZE || int'(len) > owed_left || first_page != last_page;
            if (bad)
            begin
                up_phase = PH_IDLE;
                owe(ST_BAD_FRAME, '0, 1'b1);
            end
            else
            begin
                up_phase = PH_DATA;
                up_page_len = len[6:0];
                up_left = len[6:0];
                up_page_expect = pcrc;
                up_page_crc = CRC_ONES;
                owe(ST_SEND, '0, 1'b1);
            end
        end
        else if (act == ACT_DATA && up_phase == PH_DATA)
        begin
            up_page_crc = crc_fold(up_page_crc, dbyte);
            up_total_crc = crc_fold(up_total_crc, dbyte);
            if (up_left > 1)
                up_left = up_left - 1;
            else
            begin
                up_left = '0;
                page_final = ~up_page_crc;
                if (page_final != up_page_expect)
                begin
                    up_phase = PH_IDLE;
                    owe(ST_PAGE_CRC, page_final, 1'b1);
                end
                else
                begin
                    up_count = up_count + up_page_len;
                    if (up_count < reg_total)
                    begin
                        up_phase = PH_HEADER;
                        owe(ST_PAGE_ACK, page_final, 1'b1);
                    end
                    else
                    begin
                        up_phase = PH_IDLE;
                        owe(ST_PAGE_ACK, page_final, 1'b0);
                        total_final = ~up_total_crc;
                        owe((total_final == reg_expect) ? ST_DONE : ST_TOTAL_CRC,
                            total_final, 1'b1);
                    end
                end
            end
        end
        else
        begin
            up_phase = PH_IDLE;
            owe(ST_UNEXPECTED, '0, 1'b1);
        end
    endfunction

    // Predict on each input beat, check each result beat against the oldest owed one
    always @(posedge clk)
    begin : watch_channels
        result_t want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                judge_item(item_ch.action, item_ch.page_address, item_ch.page_length,
                           item_ch.page_crc, item_ch.data_byte);
                if (row_typed)
                begin
                    void'(owed_results.pop_back());
                    owed_results.push_back(row_result);
                end
                items_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("cycle %0d: result beat with nothing owed, status %0d",
                                 cycle_count, res_ch.status);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res_ch.status === ST_DONE)
                        uploads_clean++;
                    if (res_ch.status !== want.status || res_ch.received_count !== want.count ||
                        res_ch.crc_value !== want.crc || res_ch.last_of_run !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"cycle %0d: expected status %0d count %0d crc %h last %0b,",
                                      " got status %0d count %0d crc %h last %0b"},
                                     cycle_count, want.status, want.count, want.crc, want.last,
                                     res_ch.status, res_ch.received_count, res_ch.crc_value,
                                     res_ch.last_of_run);
                    end
                end
            end
        end
    end

    // Present one input beat and hold it until taken
    task automatic offer_item(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                              input logic [PLEN_W-1:0] len, input logic [CRC_W-1:0] pcrc,
                              input logic [BYTE_W-1:0] dbyte, input bit typed,
                              input result_t typed_val);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.page_address <= addr;
        item_ch.page_length <= len;
        item_ch.page_crc <= pcrc;
        item_ch.data_byte <= dbyte;
        row_typed = typed;
        row_result = typed_val;
        offered++;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_START_ADDRESS: reg_start = val[START_W-1:0];
            REG_TOTAL_LENGTH:  reg_total = val[LEN_W-1:0];
            REG_EXPECTED_CRC:  reg_expect = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic void put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        step_row_t r;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed = 1'b0;
        plan.push_back(r);
    endfunction

    function automatic void put_item(input logic [ACTION_W-1:0] act,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [PLEN_W-1:0] len,
                                     input logic [CRC_W-1:0] pcrc,
                                     input logic [BYTE_W-1:0] dbyte, input bit typed,
                                     input status_t st, input logic [COUNT_W-1:0] cnt);
        step_row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = REG_START_ADDRESS;
        r.act = act;
        r.addr = addr;
        r.len = len;
        r.crc = pcrc;
        r.dbyte = dbyte;
        r.typed = typed;
        r.want = '{status: st, count: cnt, crc: '0, last: 1'b1};
        plan.push_back(r);
    endfunction

    initial
    begin
        logic [CRC_W-1:0] c_zero;
        logic [CRC_W-1:0] c_ff00;
        logic [CRC_W-1:0] c_55aa;
        logic [CRC_W-1:0] c_all4;
        logic [BYTE_W-1:0] payload[];
        logic [CRC_W-1:0] run_crc;
        logic [CRC_W-1:0] page_crc;
        logic [CFG_DATA_W-1:0] start_word;
        logic [CFG_DATA_W-1:0] total_word;
        logic [CFG_DATA_W-1:0] expect_word;
        int unsigned up_start;
        int unsigned up_total;
        int unsigned pos;
        int unsigned room;
        int unsigned span;
        int unsigned pick;
        int unsigned fault;
        bit range_ok;
        bit aborted;
        bit corrupt;

        // Drive every input to a known value
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_START_ADDRESS;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_START;
        item_ch.page_address = '0;
        item_ch.page_length = '0;
        item_ch.page_crc = '0;
        item_ch.data_byte = '0;
        res_ch.ready = 1'b0;
        row_typed = 1'b0;
        row_result = '0;

        // Clear the mirror
        reg_start = '0;
        reg_total = '0;
        reg_expect = '0;
        up_phase = PH_IDLE;
        up_count = '0;
        up_total_crc = CRC_ONES;
        up_page_crc = CRC_ONES;
        up_page_expect = '0;
        up_left = '0;
        up_page_len = '0;

        c_zero = ~crc_fold(CRC_ONES, 8'h00);
        c_ff00 = ~crc_fold(crc_fold(CRC_ONES, 8'hFF), 8'h00);
        c_55aa = ~crc_fold(crc_fold(CRC_ONES, 8'h55), 8'hAA);
        c_all4 = ~crc_fold(crc_fold(~c_ff00, 8'h55), 8'hAA);

        // Registers at reset: empty range, then items in the wrong phase and an unused action
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_BAD_RANGE, '0);
        put_item(ACT_HEADER, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_UNEXPECTED, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'hFF, 1'b1, ST_UNEXPECTED, '0);
        put_item(ACT_UNUSED, 16'h8000, 8'h80, 32'h8000_0000, 8'h80, 1'b1, ST_UNEXPECTED, '0);
        // Full memory upload opens; an empty page is refused
        put_reg(REG_TOTAL_LENGTH, 32'h0000_8000);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_HEADER, '0, '0, '0, '0, 1'b1, ST_BAD_FRAME, '0);
        // Top address with full length runs past the memory
        put_reg(REG_START_ADDRESS, 32'hFFFF_FFFF);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_BAD_RANGE, '0);
        // One byte at the top address, wrong total CRC
        put_reg(REG_TOTAL_LENGTH, 32'hFFFF_0001);
        put_reg(REG_EXPECTED_CRC, 32'hFFFF_FFFF);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_HEADER, 16'h7FFF, 8'd1, c_zero, 8'h5A, 1'b1, ST_SEND, '0);
        put_item(ACT_DATA, 16'h1234, 8'h33, 32'h0, 8'h00, 1'b0, ST_READY, '0);
        // Two pages around a page boundary
        put_reg(REG_START_ADDRESS, 32'd62);
        put_reg(REG_TOTAL_LENGTH, 32'd4);
        put_reg(REG_EXPECTED_CRC, c_all4);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'h11, 1'b1, ST_UNEXPECTED, '0);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_HEADER, 16'd62, 8'd4, '0, '0, 1'b1, ST_BAD_FRAME, '0);
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_HEADER, 16'd62, 8'd2, c_ff00, '0, 1'b1, ST_SEND, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'hFF, 1'b0, ST_READY, '0);
        // Restart in the middle of a page
        put_item(ACT_START, '0, '0, '0, '0, 1'b1, ST_READY, '0);
        put_item(ACT_HEADER, 16'd62, 8'd2, c_ff00, '0, 1'b1, ST_SEND, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'hFF, 1'b0, ST_READY, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'h00, 1'b0, ST_READY, '0);
        put_item(ACT_HEADER, 16'd64, 8'd2, c_55aa, '0, 1'b1, ST_SEND, 16'd2);
        put_item(ACT_DATA, '0, '0, '0, 8'h55, 1'b0, ST_READY, '0);
        put_item(ACT_DATA, '0, '0, '0, 8'hAA, 1'b0, ST_READY, '0);
        // Idle keeps the count of the finished upload
        put_item(ACT_DATA, '0, '0, '0, 8'h00, 1'b1, ST_UNEXPECTED, 16'd4);

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                offer_item(plan[i].act, plan[i].addr, plan[i].len, plan[i].crc,
                           plan[i].dbyte, plan[i].typed, plan[i].want);
        end

        // Random uploads, mostly well formed
        offered = 0;
        while (offered < RANDOM_ITEMS)
        begin
            if (offered < RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 7;
                recv_stall_pct = 58;
            end
            else if (offered < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 58;
                recv_stall_pct = 7;
            end
            else
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end

            // Pick the range: mostly short, a few long, some flush with the top
            pick = $urandom_range(99);
            up_total = (pick < 6) ? $urandom_range(700, 300) : $urandom_range(90, 1);
            up_start = $urandom_range(MEM_SIZE - up_total, 0);
            if (pick >= 6 && pick < 10)
                up_start = MEM_SIZE - up_total;
            pick = $urandom_range(99);
            if (pick < 2)
                up_total = 0;
            else if (pick < 6)
            begin
                up_total = $urandom_range(90, 2);
                up_start = MEM_SIZE - $urandom_range(up_total - 1, 1);
            end
            range_ok = up_total != 0 && up_start + up_total <= MEM_SIZE;

            payload = new[up_total];
            run_crc = CRC_ONES;
            foreach (payload[i])
            begin
                payload[i] = $urandom();
                run_crc = crc_fold(run_crc, payload[i]);
            end

            start_word = up_start;
            if ($urandom_range(9) == 0)
                start_word[31:START_W] = $urandom();
            total_word = up_total;
            if ($urandom_range(9) == 0)
                total_word[31:LEN_W] = $urandom();
            expect_word = ($urandom_range(99) < 85) ? ~run_crc : $urandom();

            settle();
            write_reg(REG_START_ADDRESS, start_word);
            write_reg(REG_TOTAL_LENGTH, total_word);
            write_reg(REG_EXPECTED_CRC, expect_word);

            // Stray beats while idle
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(3, 1))
                    offer_item($urandom_range(ACT_UNUSED, ACT_HEADER), $urandom(), $urandom(),
                               $urandom(), $urandom(), 1'b0, '0);
            end

            offer_item(ACT_START, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0, '0);

            pos = 0;
            aborted = 1'b0;
            while (range_ok && !aborted && pos < up_total)
            begin
                room = PAGE_SIZE - ((up_start + pos) % PAGE_SIZE);
                span = (up_total - pos < room) ? up_total - pos : room;
                if ($urandom_range(1))
                    span = $urandom_range(span, 1);
                page_crc = CRC_ONES;
                for (int k = 0; k < span; k++)
                    page_crc = crc_fold(page_crc, payload[pos + k]);
                page_crc = ~page_crc;
                fault = $urandom_range(99);
                corrupt = 1'b0;
                if (fault < 3)
                begin
                    // Broken header: random, off by one, or past the page end
                    case ($urandom_range(2))
                        0: offer_item(ACT_HEADER, $urandom(), $urandom(), $urandom(),
                                      $urandom(), 1'b0, '0);
                        1: offer_item(ACT_HEADER, up_start + pos + 1, span, page_crc,
                                      $urandom(), 1'b0, '0);
                        default: offer_item(ACT_HEADER, up_start + pos,
                                            room + $urandom_range(8, 1), page_crc,
                                            $urandom(), 1'b0, '0);
                    endcase
                    aborted = 1'b1;
                end
                else if (fault < 5)
                begin
                    offer_item($urandom_range(1) ? ACT_DATA : ACT_UNUSED, $urandom(),
                               $urandom(), $urandom(), $urandom(), 1'b0, '0);
                    aborted = 1'b1;
                end
                else if (fault < 6)
                begin
                    offer_item(ACT_START, $urandom(), $urandom(), $urandom(), $urandom(),
                               1'b0, '0);
                    aborted = 1'b1;
                end
                else
                begin
                    if (fault < 9)
                    begin
                        page_crc = page_crc ^ (32'h1 << $urandom_range(31));
                        corrupt = 1'b1;
                    end
                    offer_item(ACT_HEADER, up_start + pos, span, page_crc, $urandom(),
                               1'b0, '0);
                    for (int k = 0; k < span; k++)
                    begin
                        // Rarely break into the page with a start or a header
                        if ($urandom_range(199) == 0)
                        begin
                            offer_item($urandom_range(1) ? ACT_START : ACT_HEADER, $urandom(),
                                       $urandom(), $urandom(), $urandom(), 1'b0, '0);
                            aborted = 1'b1;
                            break;
                        end
                        offer_item(ACT_DATA, $urandom(), $urandom(), $urandom(),
                                   payload[pos + k], 1'b0, '0);
                    end
                    pos = pos + span;
                    if (corrupt)
                        aborted = 1'b1;
                end
            end
        end

        settle();
        $display("Run covered %0d input beats and %0d result beats; %0d uploads ended clean.",
                 items_taken, results_seen, uploads_clean);
        $display("Result mismatches: %0d, results still owed: %0d",
                 mismatches, owed_results.size());
        if (mismatches == 0 && owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
